// ----- rtl/qefa_pkg.sv -----
package qefa_pkg;

  localparam int unsigned W = 30;
  localparam logic [W-1:0] PRIME = 30'd1000000007;
  localparam logic [W-1:0] NONRES_RESET = 30'd5;
  // Barrett constant floor(2^60 / p), 31 bits
  localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] MU = MU_FULL[30:0];
  localparam logic [62:0] FERMAT_EXP = 63'd1000000005;

  localparam logic [1:0] MODE_MUL  = 2'd0;
  localparam logic [1:0] MODE_DIV  = 2'd1;
  localparam logic [1:0] MODE_POW  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [29:0] x_real;
    logic [29:0] x_root;
    logic [29:0] y_real;
    logic [29:0] y_root;
    logic [62:0] exponent;
  } in_t;

  typedef struct packed {
    logic [29:0] r_real;
    logic [29:0] r_root;
  } out_t;

  typedef struct packed {
    logic [29:0] re;
    logic [29:0] rt;
  } elem_t;

  function automatic logic [W-1:0] reduce(input logic [W-1:0] v);
    reduce = (v >= PRIME) ? (v - PRIME) : v;
  endfunction

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_mod = (s >= {1'b0, PRIME}) ? W'(s - {1'b0, PRIME}) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] neg_mod(input logic [W-1:0] a);
    neg_mod = (a == '0) ? '0 : (PRIME - a);
  endfunction

endpackage

// ----- rtl/qefa_modmul.sv -----
module qefa_modmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic        done,
  output logic [29:0] res
);

  logic [59:0] prod_r;
  logic [31:0] low_r;
  logic [30:0] q_r;
  logic [31:0] rem_r;
  logic [29:0] res_r;
  logic [3:0]  v_r;
  logic [61:0] qm;
  logic [60:0] qp;
  logic [31:0] rem1;
  logic [31:0] rem2;

  assign qm   = {31'd0, prod_r[59:29]} * {31'd0, qefa_pkg::MU};
  assign qp   = {30'd0, q_r} * {31'd0, qefa_pkg::PRIME};
  assign rem1 = rem_r - {2'd0, qefa_pkg::PRIME};
  assign rem2 = rem_r - {1'b0, qefa_pkg::PRIME, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
    prod_r <= {30'd0, a} * {30'd0, b};
    q_r    <= qm[61:31];
    low_r  <= prod_r[31:0];
    rem_r  <= low_r - qp[31:0];
    // remainder is below 3p: pick the right candidate
    if (rem_r >= {1'b0, qefa_pkg::PRIME, 1'b0}) begin
      res_r <= rem2[29:0];
    end else if (rem_r >= {2'd0, qefa_pkg::PRIME}) begin
      res_r <= rem1[29:0];
    end else begin
      res_r <= rem_r[29:0];
    end
  end

  assign done = v_r[3];
  assign res  = res_r;

endmodule

// ----- rtl/qefa_fmul.sv -----
module qefa_fmul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  qefa_pkg::elem_t         a,
  input  qefa_pkg::elem_t         b,
  input  logic [29:0]             n,
  output logic                    done,
  output qefa_pkg::elem_t         r
);

  logic        busy_r;
  logic        issue_r;
  logic        fin_r;
  logic [2:0]  step_r;
  logic [29:0] t0_r, t1_r, t2_r, t3_r;
  logic [29:0] op_a, op_b;
  logic        mm_done;
  logic [29:0] mm_res;

  always_comb begin
    case (step_r)
      3'd0:    begin op_a = a.re; op_b = b.re; end
      3'd1:    begin op_a = a.rt; op_b = b.rt; end
      3'd2:    begin op_a = n;    op_b = t1_r; end
      3'd3:    begin op_a = a.re; op_b = b.rt; end
      default: begin op_a = a.rt; op_b = b.re; end
    endcase
  end

  qefa_modmul u_mm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (issue_r),
    .a     (op_a),
    .b     (op_b),
    .done  (mm_done),
    .res   (mm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      fin_r   <= 1'b0;
      step_r  <= '0;
    end else begin
      issue_r <= 1'b0;
      fin_r   <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        issue_r <= 1'b1;
        step_r  <= '0;
      end else if (busy_r && mm_done) begin
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          step_r  <= step_r + 3'd1;
          issue_r <= 1'b1;
        end
      end
    end
    if (busy_r && mm_done) begin
      case (step_r)
        3'd0:    t0_r <= mm_res;
        3'd1:    t1_r <= mm_res;
        3'd2:    t1_r <= mm_res;
        3'd3:    t2_r <= mm_res;
        default: t3_r <= mm_res;
      endcase
    end
  end

  assign done = fin_r;
  assign r.re = qefa_pkg::add_mod(t0_r, t1_r);
  assign r.rt = qefa_pkg::add_mod(t2_r, t3_r);

endmodule

// ----- rtl/quadratic_extension_field_alu_core.sv -----
// Each field product runs on the shared modular multiplier; out_valid rises once the
// last product of an item is done and the output register is free.
// Multiply mode runs one product; power mode a square per exponent bit and a multiply
// per set bit; divide mode the norm, its power to p-2, then the conj(y) and x products.
// Throughput: one beat at a time; in_ready is low until the result is loaded out.
// Reset (synchronous, active low): sequencer idle, no result held, nonresidue back to 5.
module quadratic_extension_field_alu_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qefa_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qefa_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [29:0]       cfg_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1; // y * conj(y) gives the norm
  localparam logic [2:0] S_PSQ  = 3'd2; // square the accumulator
  localparam logic [2:0] S_PMUL = 3'd3; // multiply by the base
  localparam logic [2:0] S_CONJ = 3'd4; // inverse norm times conj(y)
  localparam logic [2:0] S_XMUL = 3'd5; // times x (or y in multiply mode)
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic             go_r, go_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [62:0]      exp_r, exp_nxt;
  qefa_pkg::elem_t  acc_r, acc_nxt;
  qefa_pkg::elem_t  base_r, base_nxt;
  qefa_pkg::elem_t  xs_r, xs_nxt;
  qefa_pkg::elem_t  yc_r, yc_nxt;
  logic [29:0]      nres_r;
  logic             out_valid_r, out_valid_nxt;
  qefa_pkg::out_t   out_r, out_nxt;

  qefa_pkg::elem_t  opnd;
  qefa_pkg::elem_t  fm_r;
  logic             fm_done;
  qefa_pkg::elem_t  xin, yin;
  logic [29:0]      nred;
  logic             post_pow;

  assign nred   = qefa_pkg::reduce(nres_r);
  assign xin.re = qefa_pkg::reduce(in_data.x_real);
  assign xin.rt = qefa_pkg::reduce(in_data.x_root);
  assign yin.re = qefa_pkg::reduce(in_data.y_real);
  assign yin.rt = qefa_pkg::reduce(in_data.y_root);

  // Pick the second operand of the field product for the current step
  always_comb begin
    case (state_r)
      S_PSQ:   opnd = acc_r;
      S_PMUL:  opnd = base_r;
      S_XMUL:  opnd = xs_r;
      default: opnd = yc_r;
    endcase
  end

  qefa_fmul u_fmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .a     (acc_r),
    .b     (opnd),
    .n     (nred),
    .done  (fm_done),
    .r     (fm_r)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // last exponent bit handled: leave the power loop
  assign post_pow  = (cnt_r == 6'd0);

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    xs_nxt        = xs_r;
    yc_nxt        = yc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_data.mode;
          case (in_data.mode)
            qefa_pkg::MODE_MUL: begin
              acc_nxt   = xin;
              xs_nxt    = yin;
              state_nxt = S_XMUL;
              go_nxt    = 1'b1;
            end
            qefa_pkg::MODE_DIV: begin
              acc_nxt   = yin;
              yc_nxt.re = yin.re;
              yc_nxt.rt = qefa_pkg::neg_mod(yin.rt);
              xs_nxt    = xin;
              state_nxt = S_NORM;
              go_nxt    = 1'b1;
            end
            qefa_pkg::MODE_POW: begin
              acc_nxt   = '{re: 30'd1, rt: 30'd0};
              base_nxt  = xin;
              exp_nxt   = in_data.exponent;
              cnt_nxt   = 6'd62;
              state_nxt = S_PSQ;
              go_nxt    = 1'b1;
            end
            default: begin
              acc_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_NORM: begin
        if (fm_done) begin
          // norm sits in the real part; raise it to p-2 for its inverse
          base_nxt  = fm_r;
          acc_nxt   = '{re: 30'd1, rt: 30'd0};
          exp_nxt   = qefa_pkg::FERMAT_EXP;
          cnt_nxt   = 6'd29;
          state_nxt = S_PSQ;
          go_nxt    = 1'b1;
        end
      end
      S_PSQ: begin
        if (fm_done) begin
          acc_nxt = fm_r;
          if (exp_r[cnt_r]) begin
            state_nxt = S_PMUL;
            go_nxt    = 1'b1;
          end else if (post_pow) begin
            state_nxt = (mode_r == qefa_pkg::MODE_DIV) ? S_CONJ : S_DONE;
            go_nxt    = (mode_r == qefa_pkg::MODE_DIV);
          end else begin
            cnt_nxt = cnt_r - 6'd1;
            go_nxt  = 1'b1;
          end
        end
      end
      S_PMUL: begin
        if (fm_done) begin
          acc_nxt = fm_r;
          if (post_pow) begin
            state_nxt = (mode_r == qefa_pkg::MODE_DIV) ? S_CONJ : S_DONE;
            go_nxt    = (mode_r == qefa_pkg::MODE_DIV);
          end else begin
            cnt_nxt   = cnt_r - 6'd1;
            state_nxt = S_PSQ;
            go_nxt    = 1'b1;
          end
        end
      end
      S_CONJ: begin
        if (fm_done) begin
          acc_nxt   = fm_r;
          state_nxt = S_XMUL;
          go_nxt    = 1'b1;
        end
      end
      S_XMUL: begin
        if (fm_done) begin
          acc_nxt   = fm_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt.r_real = acc_r.re;
          out_nxt.r_root = acc_r.rt;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      nres_r      <= qefa_pkg::NONRES_RESET;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        nres_r <= cfg_data;
      end
    end
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
    exp_r  <= exp_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    xs_r   <= xs_nxt;
    yc_r   <= yc_nxt;
    out_r  <= out_nxt;
  end

endmodule
